### src/bit_range_move_clear_engine_assert.svh
`ifndef BIT_RANGE_MOVE_CLEAR_ENGINE_ASSERT_SVH
`define BIT_RANGE_MOVE_CLEAR_ENGINE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BRMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BRMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/brmc_pkg.sv
package brmc_pkg;
    localparam int MEM_BYTES  = 4096;
    localparam int ADDR_W     = 12;
    localparam int TOTAL_BITS = MEM_BYTES * 8;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_MOVE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_SRC,
        ST_DST,
        ST_WR,
        ST_FIN
    } t_state;
endpackage

### src/bit_range_move_clear_engine.sv
// channel   direction  handshake            payload
// request   in         i_valid / o_ready    i_command i_byte_address i_write_byte
//                                           i_source_bit i_dest_bit i_bit_count
// result    out        o_valid / i_ready    o_read_byte o_status
//
// After reset the store is swept to zero, one byte a cycle, with o_ready low.
// Write: the byte is written as the request is taken. Read: the registered memory read
// is captured in ST_RD. Clear and move: per destination byte touched, a source read,
// a destination read and a write back through one memory write port.
// One request at a time; a finished result waits in the output register while the
// next request is taken, and a stalled result holds the engine only at its end.
module bit_range_move_clear_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [11:0] i_byte_address,
    input  logic [7:0]  i_write_byte,
    input  logic [14:0] i_source_bit,
    input  logic [14:0] i_dest_bit,
    input  logic [15:0] i_bit_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_read_byte,
    output logic        o_status
);
    import brmc_pkg::*;
    `include "bit_range_move_clear_engine_assert.svh"

    logic [7:0] mem [MEM_BYTES];

    t_state r_state, n_state;
    logic [ADDR_W-1:0] r_d;
    logic [ADDR_W-1:0] r_end;
    logic              r_asc;
    logic              r_clear;
    logic [14:0]       r_dst;
    logic [16:0]       r_hi;
    logic [16:0]       r_off;
    logic [15:0]       r_src;
    logic [7:0]        r_qa, r_qb;
    logic [7:0]        r_prd;
    logic              r_pst;
    logic              r_ov;
    logic [7:0]        r_ord;
    logic              r_ost;

    logic              we, rea, reb;
    logic [ADDR_W-1:0] wa, ra_a, ra_b;
    logic [7:0]        wd;

    logic [16:0] hi_in;
    logic [16:0] last_in;
    logic        range_bad, no_op;
    logic [16:0] ss;
    logic [7:0]  mask, sdat;
    logic [14:0] pos [8];
    logic        out_load;

    assign hi_in    = 17'(i_dest_bit) + 17'(i_bit_count);
    assign last_in  = hi_in - 17'd1;
    assign no_op    = (i_bit_count == 16'd0) ||
                      ((i_command == CMD_MOVE) && (i_source_bit == i_dest_bit));
    assign range_bad = (hi_in > 17'(TOTAL_BITS)) ||
                       ((i_command == CMD_MOVE) &&
                        (17'(i_source_bit) + 17'(i_bit_count) > 17'(TOTAL_BITS)));

    assign ss   = {2'b00, r_d, 3'b000} + r_off;
    assign sdat = 8'(r_src >> r_off[2:0]);

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            pos[k]  = {r_d, 3'b000} + 15'(k);
            mask[k] = (pos[k] >= r_dst) && ({2'b00, pos[k]} < r_hi);
        end
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign out_load = (r_state == ST_FIN) && (!r_ov || i_ready);

    always_comb begin
        n_state = r_state;
        we   = 1'b0;
        wa   = r_d;
        wd   = 8'h00;
        rea  = 1'b0;
        reb  = 1'b0;
        ra_a = r_d;
        ra_b = r_d;
        case (r_state)
            ST_CLR: begin
                we = 1'b1;
                if (r_d == ADDR_W'(MEM_BYTES - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_WRITE: begin
                            we = 1'b1;
                            wa = i_byte_address;
                            wd = i_write_byte;
                            n_state = ST_FIN;
                        end
                        CMD_READ: begin
                            rea  = 1'b1;
                            ra_a = i_byte_address;
                            n_state = ST_RD;
                        end
                        default: begin
                            if (no_op || range_bad) n_state = ST_FIN;
                            else n_state = ST_SRC;
                        end
                    endcase
                end
            end
            ST_RD: n_state = ST_FIN;
            ST_SRC: begin
                rea  = 1'b1;
                reb  = 1'b1;
                ra_a = ss[14:3];
                ra_b = ss[14:3] + ADDR_W'(1);
                n_state = ST_DST;
            end
            ST_DST: begin
                rea  = 1'b1;
                ra_a = r_d;
                n_state = ST_WR;
            end
            ST_WR: begin
                we = 1'b1;
                wd = (sdat & mask) | (r_qa & ~mask);
                n_state = (r_d == r_end) ? ST_FIN : ST_SRC;
            end
            ST_FIN: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        if (rea) r_qa <= mem[ra_a];
        if (reb) r_qb <= mem[ra_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_d     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            if (r_state == ST_CLR) r_d <= r_d + ADDR_W'(1);
            if ((r_state == ST_IDLE) && i_valid) begin
                if ((i_command == CMD_CLEAR) || (i_dest_bit < i_source_bit)) begin
                    r_d <= i_dest_bit[14:3];
                end else begin
                    r_d <= last_in[14:3];
                end
            end
            if ((r_state == ST_WR) && (r_d != r_end)) begin
                r_d <= r_asc ? r_d + ADDR_W'(1) : r_d - ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_valid) begin
            r_clear <= (i_command == CMD_CLEAR);
            r_asc   <= (i_command == CMD_CLEAR) || (i_dest_bit < i_source_bit);
            r_end   <= ((i_command == CMD_CLEAR) || (i_dest_bit < i_source_bit)) ?
                       last_in[14:3] : i_dest_bit[14:3];
            r_dst   <= i_dest_bit;
            r_hi    <= hi_in;
            r_off   <= 17'(i_source_bit) - 17'(i_dest_bit);
            r_prd   <= 8'h00;
            r_pst   <= (i_command inside {CMD_CLEAR, CMD_MOVE}) &&
                       (i_bit_count != 16'd0) && range_bad;
        end
        if (r_state == ST_RD) r_prd <= r_qa;
        if (r_state == ST_DST) r_src <= r_clear ? 16'h0000 : {r_qb, r_qa};
        if (out_load) begin
            r_ord <= r_prd;
            r_ost <= r_pst;
        end
    end

    assign o_valid     = r_ov;
    assign o_read_byte = r_ord;
    assign o_status    = r_ost;

    `BRMC_ASSERT_NOW(a_write_only_on_cmd, we && o_ready,
        i_valid && (i_command == CMD_WRITE), "memory write while idle without write request")
    `BRMC_ASSERT_NOW(a_clear_writes_zero, (r_state == ST_WR) && r_clear,
        (wd & mask) == 8'h00, "clear left a bit set inside its range")
    `BRMC_ASSERT_NEXT(a_result_from_fin, !r_ov && !out_load, !r_ov,
        "result appeared without finishing a request")
endmodule
